FILE: hdl/ahkr_pkg.sv
// Shared types and constants for the analog hysteresis and key repeat block.
// Used by ahkr_frame and analog_hysteresis_key_repeat; depends on nothing.
`default_nettype none

package ahkr_pkg;

  localparam int BTN_W  = 16;
  localparam int ANA_W  = 10;
  localparam int CNT_W  = 16;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 8;

  typedef enum logic [CFG_IW-1:0] {
    CFG_STICK_PRESS   = 3'd0,
    CFG_STICK_HOLD    = 3'd1,
    CFG_TRIGGER_PRESS = 3'd2,
    CFG_TRIGGER_HOLD  = 3'd3,
    CFG_REPEAT_DELAY  = 3'd4,
    CFG_REPEAT_MASK   = 3'd5
  } cfg_index_t;

  localparam logic [6:0] STICK_PRESS_RST   = 7'd52;
  localparam logic [6:0] STICK_HOLD_RST    = 7'd15;
  localparam logic [7:0] TRIGGER_PRESS_RST = 8'd80;
  localparam logic [7:0] TRIGGER_HOLD_RST  = 8'd40;
  localparam logic [7:0] REPEAT_DELAY_RST  = 8'd20;
  localparam logic [7:0] REPEAT_MASK_RST   = 8'd3;

  typedef struct packed {
    logic [6:0] stick_press;
    logic [6:0] stick_hold;
    logic [7:0] trigger_press;
    logic [7:0] trigger_hold;
    logic [7:0] repeat_delay;
    logic [7:0] repeat_mask;
  } cfg_t;

  typedef struct packed {
    logic [BTN_W-1:0] buttons;
    logic [ANA_W-1:0] analog;
    logic [CNT_W-1:0] count;
  } state_t;

  typedef struct packed {
    logic [BTN_W-1:0] buttons;
    logic [7:0]       stick_x;
    logic [7:0]       stick_y;
    logic [7:0]       cstick_x;
    logic [7:0]       cstick_y;
    logic [7:0]       trigger_left;
    logic [7:0]       trigger_right;
  } frame_t;

  typedef struct packed {
    logic [ANA_W-1:0] analog_held;
    logic [ANA_W-1:0] analog_pressed;
    logic [ANA_W-1:0] analog_released;
    logic [ANA_W-1:0] analog_repeat;
    logic [BTN_W-1:0] button_pressed;
    logic [BTN_W-1:0] button_released;
    logic [BTN_W-1:0] button_repeat;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/ahkr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module ahkr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic                                 re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ahkr_frame.sv
// Evaluates one controller frame against its stored history: hysteresis,
// edges, steady count and repeat decision. Depends on ahkr_pkg.
`default_nettype none

module ahkr_frame (
  input  wire ahkr_pkg::cfg_t   cfg,
  input  wire ahkr_pkg::frame_t frame,
  input  wire ahkr_pkg::state_t prev,
  input  wire logic             ctrl_ok,
  output ahkr_pkg::state_t      next,
  output ahkr_pkg::result_t     res
);

  logic [7:0]                 axis [4];
  logic [ahkr_pkg::ANA_W-1:0] held;
  logic [6:0]                 neg_lvl [4];
  logic [6:0]                 pos_lvl [4];
  logic [8:0]                 neg_sum [4];
  logic [7:0]                 tl_lvl;
  logic [7:0]                 tr_lvl;
  logic                       steady;
  logic [ahkr_pkg::CNT_W-1:0] cnt;
  logic                       rep;

  assign axis[0] = frame.stick_x;
  assign axis[1] = frame.stick_y;
  assign axis[2] = frame.cstick_x;
  assign axis[3] = frame.cstick_y;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      neg_lvl[i] = prev.analog[2*i]   ? cfg.stick_hold : cfg.stick_press;
      pos_lvl[i] = prev.analog[2*i+1] ? cfg.stick_hold : cfg.stick_press;
      neg_sum[i] = {axis[i][7], axis[i]} + {2'b00, neg_lvl[i]};
      held[2*i]   = neg_sum[i][8];
      held[2*i+1] = $signed({axis[i][7], axis[i]}) > $signed({2'b00, pos_lvl[i]});
    end
    tl_lvl  = prev.analog[8] ? cfg.trigger_hold : cfg.trigger_press;
    tr_lvl  = prev.analog[9] ? cfg.trigger_hold : cfg.trigger_press;
    held[8] = frame.trigger_left > tl_lvl;
    held[9] = frame.trigger_right > tr_lvl;
  end

  always_comb begin
    steady = ctrl_ok && (frame.buttons == prev.buttons) && (held == prev.analog);
    if (!steady) begin
      cnt = '0;
    end else if (&prev.count) begin
      cnt = prev.count - {8'h00, cfg.repeat_mask};
    end else begin
      cnt = prev.count + 16'd1;
    end
    rep = (cnt >= {8'h00, cfg.repeat_delay}) && ((cnt & {8'h00, cfg.repeat_mask}) == '0);
  end

  always_comb begin
    next.buttons        = frame.buttons;
    next.analog         = held;
    next.count          = cnt;
    res.analog_held     = held;
    res.analog_pressed  = held & ~prev.analog;
    res.analog_released = prev.analog & ~held;
    res.analog_repeat   = rep ? held : (held & ~prev.analog);
    res.button_pressed  = frame.buttons & ~prev.buttons;
    res.button_released = prev.buttons & ~frame.buttons;
    res.button_repeat   = rep ? frame.buttons : (frame.buttons & ~prev.buttons);
  end

endmodule

`default_nettype wire

FILE: hdl/analog_hysteresis_key_repeat.sv
// Top level of the analog hysteresis and key repeat block.
// Depends on ahkr_pkg, ahkr_ram and ahkr_frame.
//
// The block takes one controller frame word per clock and returns one result
// word per accepted frame. A read stage fetches the controller's history from
// a small RAM; an evaluate stage then evaluates the frame, writes the new
// history back and loads the output register. The most recent write-back is
// forwarded, so consecutive frames of the same controller see each other's
// history. History reads as zero until a controller's entry is first
// written; frames for a controller index at or above CONTROLLERS see a zero
// history and leave state unchanged. Only output back-pressure slows input.
`default_nettype none

module analog_hysteresis_key_repeat #(
  parameter int CONTROLLERS = 4
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [ahkr_pkg::CFG_IW-1:0]        cfg_index,
  input  wire logic [ahkr_pkg::CFG_DW-1:0]        cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         in_controller,
  input  wire logic [ahkr_pkg::BTN_W-1:0]         in_buttons,
  input  wire logic signed [7:0]                  in_stick_x,
  input  wire logic signed [7:0]                  in_stick_y,
  input  wire logic signed [7:0]                  in_cstick_x,
  input  wire logic signed [7:0]                  in_cstick_y,
  input  wire logic [7:0]                         in_trigger_left,
  input  wire logic [7:0]                         in_trigger_right,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [ahkr_pkg::ANA_W-1:0]              out_analog_held,
  output logic [ahkr_pkg::ANA_W-1:0]              out_analog_pressed,
  output logic [ahkr_pkg::ANA_W-1:0]              out_analog_released,
  output logic [ahkr_pkg::ANA_W-1:0]              out_analog_repeat,
  output logic [ahkr_pkg::BTN_W-1:0]              out_button_pressed,
  output logic [ahkr_pkg::BTN_W-1:0]              out_button_released,
  output logic [ahkr_pkg::BTN_W-1:0]              out_button_repeat
);

  localparam int AW = (CONTROLLERS > 1) ? $clog2(CONTROLLERS) : 1;
  localparam int SW = $bits(ahkr_pkg::state_t);

  ahkr_pkg::cfg_t    cfg_r;
  logic              s1_valid_r;
  logic              s1_ok_r;
  logic [AW-1:0]     s1_addr_r;
  ahkr_pkg::frame_t  s1_frame_r;
  logic [CONTROLLERS-1:0] live_r;
  logic              wb_valid_r;
  logic [AW-1:0]     wb_addr_r;
  ahkr_pkg::state_t  wb_data_r;
  logic              out_valid_r;
  ahkr_pkg::result_t out_res_r;

  logic              advance;
  logic              accept;
  logic [AW+1:0]     ctrl_wide;
  logic              ctrl_ok;
  logic [AW-1:0]     rd_addr;
  logic [SW-1:0]     ram_rdata;
  ahkr_pkg::state_t  prev;
  ahkr_pkg::state_t  next;
  ahkr_pkg::result_t res;
  logic              wr_en;

  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !advance;
  assign accept    = in_valid && !in_stall;
  assign ctrl_wide = (AW+2)'(in_controller);
  assign ctrl_ok   = ctrl_wide < (AW+2)'(CONTROLLERS);
  assign rd_addr   = ctrl_wide[AW-1:0];
  assign wr_en     = s1_valid_r && advance && s1_ok_r;

  always_comb begin
    if (!s1_ok_r) begin
      prev = '0;
    end else if (wb_valid_r && wb_addr_r == s1_addr_r) begin
      prev = wb_data_r;
    end else if (live_r[s1_addr_r]) begin
      prev = ahkr_pkg::state_t'(ram_rdata);
    end else begin
      prev = '0;
    end
  end

  ahkr_ram #(
    .WIDTH (SW),
    .DEPTH (CONTROLLERS)
  ) u_hist (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr_r),
    .wdata (SW'(next)),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  ahkr_frame u_frame (
    .cfg     (cfg_r),
    .frame   (s1_frame_r),
    .prev    (prev),
    .ctrl_ok (s1_ok_r),
    .next    (next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stick_press   <= ahkr_pkg::STICK_PRESS_RST;
      cfg_r.stick_hold    <= ahkr_pkg::STICK_HOLD_RST;
      cfg_r.trigger_press <= ahkr_pkg::TRIGGER_PRESS_RST;
      cfg_r.trigger_hold  <= ahkr_pkg::TRIGGER_HOLD_RST;
      cfg_r.repeat_delay  <= ahkr_pkg::REPEAT_DELAY_RST;
      cfg_r.repeat_mask   <= ahkr_pkg::REPEAT_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ahkr_pkg::CFG_STICK_PRESS:   cfg_r.stick_press   <= cfg_data[6:0];
        ahkr_pkg::CFG_STICK_HOLD:    cfg_r.stick_hold    <= cfg_data[6:0];
        ahkr_pkg::CFG_TRIGGER_PRESS: cfg_r.trigger_press <= cfg_data;
        ahkr_pkg::CFG_TRIGGER_HOLD:  cfg_r.trigger_hold  <= cfg_data;
        ahkr_pkg::CFG_REPEAT_DELAY:  cfg_r.repeat_delay  <= cfg_data;
        ahkr_pkg::CFG_REPEAT_MASK:   cfg_r.repeat_mask   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      live_r      <= '0;
      wb_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (wr_en) begin
        live_r[s1_addr_r] <= 1'b1;
        wb_valid_r        <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok_r                  <= ctrl_ok;
      s1_addr_r                <= rd_addr;
      s1_frame_r.buttons       <= in_buttons;
      s1_frame_r.stick_x       <= in_stick_x;
      s1_frame_r.stick_y       <= in_stick_y;
      s1_frame_r.cstick_x      <= in_cstick_x;
      s1_frame_r.cstick_y      <= in_cstick_y;
      s1_frame_r.trigger_left  <= in_trigger_left;
      s1_frame_r.trigger_right <= in_trigger_right;
    end
    if (wr_en) begin
      wb_addr_r <= s1_addr_r;
      wb_data_r <= next;
    end
    if (advance && s1_valid_r) begin
      out_res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_analog_held     = out_res_r.analog_held;
  assign out_analog_pressed  = out_res_r.analog_pressed;
  assign out_analog_released = out_res_r.analog_released;
  assign out_analog_repeat   = out_res_r.analog_repeat;
  assign out_button_pressed  = out_res_r.button_pressed;
  assign out_button_released = out_res_r.button_released;
  assign out_button_repeat   = out_res_r.button_repeat;

endmodule

`default_nettype wire

FILE: bench/analog_hysteresis_key_repeat_test.sv
// Self-checking bench for analog_hysteresis_key_repeat: frames go in through a queue-fed driver.
// A behavioral mirror of the hysteresis and repeat logic predicts every result word.
// Depends on ahkr_pkg and the block's RTL only.
module analog_hysteresis_key_repeat_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PADS = 4;
  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_FRAMES = 40;

  typedef struct packed {
    logic             drain;
    logic [1:0]       pad;
    ahkr_pkg::frame_t frame;
  } pad_frame_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ahkr_pkg::CFG_IW-1:0] cfg_index = ahkr_pkg::CFG_STICK_PRESS;
  logic [ahkr_pkg::CFG_DW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_controller = '0;
  logic [ahkr_pkg::BTN_W-1:0] in_buttons = '0;
  logic [7:0] in_stick_x = '0;
  logic [7:0] in_stick_y = '0;
  logic [7:0] in_cstick_x = '0;
  logic [7:0] in_cstick_y = '0;
  logic [7:0] in_trigger_left = '0;
  logic [7:0] in_trigger_right = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ahkr_pkg::ANA_W-1:0] out_analog_held;
  logic [ahkr_pkg::ANA_W-1:0] out_analog_pressed;
  logic [ahkr_pkg::ANA_W-1:0] out_analog_released;
  logic [ahkr_pkg::ANA_W-1:0] out_analog_repeat;
  logic [ahkr_pkg::BTN_W-1:0] out_button_pressed;
  logic [ahkr_pkg::BTN_W-1:0] out_button_released;
  logic [ahkr_pkg::BTN_W-1:0] out_button_repeat;

  ahkr_pkg::cfg_t levels;
  logic [ahkr_pkg::BTN_W-1:0] prev_buttons [PADS] = '{default: '0};
  logic [ahkr_pkg::ANA_W-1:0] prev_analog [PADS] = '{default: '0};
  logic [ahkr_pkg::CNT_W-1:0] steady_frames [PADS] = '{default: '0};

  pad_frame_t frames_to_send [$];
  ahkr_pkg::result_t edge_reports_due [$];
  pad_frame_t on_bus;
  logic drain_next = 1'b0;

  int idle_pct = 23;
  int stall_pct = 23;
  int unsigned frames_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned repeat_frames = 0;
  int unsigned mismatches = 0;
  int unsigned settings_used = 0;
  int unsigned quiet_cycles = 0;

  analog_hysteresis_key_repeat #(.CONTROLLERS(PADS)) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_controller       (in_controller),
    .in_buttons          (in_buttons),
    .in_stick_x          (in_stick_x),
    .in_stick_y          (in_stick_y),
    .in_cstick_x         (in_cstick_x),
    .in_cstick_y         (in_cstick_y),
    .in_trigger_left     (in_trigger_left),
    .in_trigger_right    (in_trigger_right),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_analog_held     (out_analog_held),
    .out_analog_pressed  (out_analog_pressed),
    .out_analog_released (out_analog_released),
    .out_analog_repeat   (out_analog_repeat),
    .out_button_pressed  (out_button_pressed),
    .out_button_released (out_button_released),
    .out_button_repeat   (out_button_repeat)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [1:0] stick_dirs(input logic [7:0] raw, input logic [1:0] was);
    int value;
    int neg_level;
    int pos_level;
    value = $signed(raw);
    neg_level = was[0] ? levels.stick_hold : levels.stick_press;
    pos_level = was[1] ? levels.stick_hold : levels.stick_press;
    return {value > pos_level, value < -neg_level};
  endfunction

  function automatic logic trigger_bit(input logic [7:0] raw, input logic was);
    return raw > (was ? levels.trigger_hold : levels.trigger_press);
  endfunction

  function automatic ahkr_pkg::result_t judge_frame(input pad_frame_t f);
    logic [ahkr_pkg::BTN_W-1:0] was_buttons;
    logic [ahkr_pkg::ANA_W-1:0] was_analog;
    logic [ahkr_pkg::ANA_W-1:0] held;
    logic [ahkr_pkg::CNT_W-1:0] count;
    logic known;
    logic rep;
    ahkr_pkg::result_t r;
    known = f.pad < PADS;
    was_buttons = known ? prev_buttons[f.pad] : '0;
    was_analog = known ? prev_analog[f.pad] : '0;
    count = known ? steady_frames[f.pad] : '0;
    held = {trigger_bit(f.frame.trigger_right, was_analog[9]),
            trigger_bit(f.frame.trigger_left, was_analog[8]),
            stick_dirs(f.frame.cstick_y, was_analog[7:6]),
            stick_dirs(f.frame.cstick_x, was_analog[5:4]),
            stick_dirs(f.frame.stick_y, was_analog[3:2]),
            stick_dirs(f.frame.stick_x, was_analog[1:0])};
    if (known && f.frame.buttons == was_buttons && held == was_analog) begin
      count = (count == 16'hFFFF) ? 16'hFFFF - levels.repeat_mask : count + 16'd1;
    end else begin
      count = '0;
    end
    rep = (count >= levels.repeat_delay) && ((count & {8'h00, levels.repeat_mask}) == 16'd0);
    r.analog_held = held;
    r.analog_pressed = held & ~was_analog;
    r.analog_released = was_analog & ~held;
    r.analog_repeat = rep ? held : r.analog_pressed;
    r.button_pressed = f.frame.buttons & ~was_buttons;
    r.button_released = was_buttons & ~f.frame.buttons;
    r.button_repeat = rep ? f.frame.buttons : r.button_pressed;
    if (rep) begin
      repeat_frames++;
    end
    if (known) begin
      prev_buttons[f.pad] = f.frame.buttons;
      prev_analog[f.pad] = held;
      steady_frames[f.pad] = count;
    end
    return r;
  endfunction

  function automatic logic [7:0] pick_axis();
    int v;
    case ($urandom_range(3))
      0: v = int'($urandom_range(255)) - 128;
      1, 2: begin
        v = ($urandom_range(1) ? levels.stick_press : levels.stick_hold) + $urandom_range(4) - 2;
        if ($urandom_range(1)) begin
          v = -v;
        end
      end
      default: v = 0;
    endcase
    if (v > 127) v = 127;
    if (v < -128) v = -128;
    return v[7:0];
  endfunction

  function automatic logic [7:0] pick_trigger();
    int v;
    case ($urandom_range(3))
      0: v = $urandom_range(255);
      1, 2: v = ($urandom_range(1) ? levels.trigger_press : levels.trigger_hold)
                + $urandom_range(4) - 2;
      default: v = 0;
    endcase
    if (v > 255) v = 255;
    if (v < 0) v = 0;
    return v[7:0];
  endfunction

  function automatic pad_frame_t random_frame(input logic [1:0] pad);
    pad_frame_t f;
    f.drain = 1'b0;
    f.pad = pad;
    case ($urandom_range(3))
      0: f.frame.buttons = 16'h1 << $urandom_range(15);
      1: f.frame.buttons = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: f.frame.buttons = 16'($urandom);
    endcase
    f.frame.stick_x = pick_axis();
    f.frame.stick_y = pick_axis();
    f.frame.cstick_x = pick_axis();
    f.frame.cstick_y = pick_axis();
    f.frame.trigger_left = pick_trigger();
    f.frame.trigger_right = pick_trigger();
    return f;
  endfunction

  task automatic push_frame(input pad_frame_t f);
    f.drain = drain_next;
    drain_next = 1'b0;
    frames_to_send.push_back(f);
  endtask

  task automatic directed(input logic [1:0] pad, input logic [15:0] buttons,
                          input logic [7:0] sx, input logic [7:0] sy,
                          input logic [7:0] cx, input logic [7:0] cy,
                          input logic [7:0] tl, input logic [7:0] tr);
    pad_frame_t f;
    f.drain = 1'b0;
    f.pad = pad;
    f.frame = {buttons, sx, sy, cx, cy, tl, tr};
    push_frame(f);
  endtask

  task automatic run_random(input int count);
    int left;
    int run_len;
    pad_frame_t base;
    pad_frame_t f;
    left = count;
    while (left > 0) begin
      base = random_frame(2'($urandom_range(PADS - 1)));
      if ($urandom_range(9) < 7) begin
        run_len = $urandom_range(40, 2);
      end else begin
        run_len = 1;
        base = random_frame(2'($urandom_range(PADS - 1)));
      end
      repeat (run_len) begin
        f = base;
        if ($urandom_range(11) == 0) begin
          f.frame.buttons = f.frame.buttons ^ (16'h1 << $urandom_range(15));
        end else if ($urandom_range(11) == 0) begin
          f = random_frame(2'($urandom_range(PADS - 1)));
        end
        push_frame(f);
        left = left - 1;
        if (left == count / 2) begin
          drain_next = 1'b1;
        end
      end
    end
  endtask

  task automatic write_level(input ahkr_pkg::cfg_index_t idx, input logic [7:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      ahkr_pkg::CFG_STICK_PRESS:   levels.stick_press = value[6:0];
      ahkr_pkg::CFG_STICK_HOLD:    levels.stick_hold = value[6:0];
      ahkr_pkg::CFG_TRIGGER_PRESS: levels.trigger_press = value;
      ahkr_pkg::CFG_TRIGGER_HOLD:  levels.trigger_hold = value;
      ahkr_pkg::CFG_REPEAT_DELAY:  levels.repeat_delay = value;
      ahkr_pkg::CFG_REPEAT_MASK:   levels.repeat_mask = value;
      default: ;
    endcase
  endtask

  task automatic apply_levels(input logic [7:0] sp, input logic [7:0] sh,
                              input logic [7:0] tp, input logic [7:0] th,
                              input logic [7:0] dly, input logic [7:0] msk);
    write_level(ahkr_pkg::CFG_STICK_PRESS, sp);
    write_level(ahkr_pkg::CFG_STICK_HOLD, sh);
    write_level(ahkr_pkg::CFG_TRIGGER_PRESS, tp);
    write_level(ahkr_pkg::CFG_TRIGGER_HOLD, th);
    write_level(ahkr_pkg::CFG_REPEAT_DELAY, dly);
    write_level(ahkr_pkg::CFG_REPEAT_MASK, msk);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic settle();
    @(negedge clk);
    while (frames_to_send.size() != 0 || in_valid || edge_reports_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result word %0d, %s: expected %h, got %h", results_checked, field, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : send_frames
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        edge_reports_due.push_back(judge_frame(on_bus));
        frames_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (frames_to_send.size() != 0
            && !(frames_to_send[0].drain && edge_reports_due.size() != 0)
            && $urandom_range(99) >= idle_pct) begin
          on_bus = frames_to_send.pop_front();
          in_valid <= 1'b1;
          in_controller <= on_bus.pad;
          in_buttons <= on_bus.frame.buttons;
          in_stick_x <= on_bus.frame.stick_x;
          in_stick_y <= on_bus.frame.stick_y;
          in_cstick_x <= on_bus.frame.cstick_x;
          in_cstick_y <= on_bus.frame.cstick_y;
          in_trigger_left <= on_bus.frame.trigger_left;
          in_trigger_right <= on_bus.frame.trigger_right;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_results
    ahkr_pkg::result_t due;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (edge_reports_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result word %0d arrived with nothing outstanding", results_checked);
          end
        end else begin
          due = edge_reports_due.pop_front();
          check_field("analog_held", 16'(due.analog_held), 16'(out_analog_held));
          check_field("analog_pressed", 16'(due.analog_pressed), 16'(out_analog_pressed));
          check_field("analog_released", 16'(due.analog_released),
                      16'(out_analog_released));
          check_field("analog_repeat", 16'(due.analog_repeat), 16'(out_analog_repeat));
          check_field("button_pressed", due.button_pressed, out_button_pressed);
          check_field("button_released", due.button_released, out_button_released);
          check_field("button_repeat", due.button_repeat, out_button_repeat);
        end
        results_checked++;
      end
      out_stall <= $urandom_range(99) < stall_pct;
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("analog_hysteresis_key_repeat regression: fail");
      $finish;
    end
  end

  initial begin : run_test
    pad_frame_t hold_frame;
    levels = {ahkr_pkg::STICK_PRESS_RST, ahkr_pkg::STICK_HOLD_RST,
              ahkr_pkg::TRIGGER_PRESS_RST, ahkr_pkg::TRIGGER_HOLD_RST,
              ahkr_pkg::REPEAT_DELAY_RST, ahkr_pkg::REPEAT_MASK_RST};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Strict thresholds at reset levels, then hysteresis hold and release.
    directed(2'd0, 16'h0000, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    directed(2'd0, 16'hFFFF, -8'sd52, 8'd52, -8'sd52, 8'd52, 8'd80, 8'd80);
    directed(2'd0, 16'hFFFF, -8'sd53, 8'd53, -8'sd53, 8'd53, 8'd81, 8'd81);
    directed(2'd0, 16'h0000, -8'sd16, 8'd16, -8'sd16, 8'd16, 8'd41, 8'd41);
    directed(2'd0, 16'h0000, -8'sd15, 8'd15, -8'sd15, 8'd15, 8'd40, 8'd40);
    directed(2'd0, 16'h0000, 8'd53, -8'sd53, 8'd53, -8'sd53, 8'd0, 8'd0);
    directed(2'd0, 16'h0000, 8'd16, -8'sd16, 8'd16, -8'sd16, 8'd0, 8'd0);
    directed(2'd1, 16'hFFFF, 8'h80, 8'h80, 8'h80, 8'h80, 8'hFF, 8'hFF);
    directed(2'd1, 16'hFFFF, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'hFF, 8'hFF);
    directed(2'd1, 16'h0000, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h00, 8'h00);
    directed(2'd2, 16'h5555, 8'h80, 8'h7F, 8'h00, 8'h80, 8'hFF, 8'h00);
    directed(2'd3, 16'hAAAA, 8'h7F, 8'h80, 8'h80, 8'h00, 8'h00, 8'hFF);
    directed(2'd2, 16'hAAAA, 8'h80, 8'h7F, 8'h00, 8'h80, 8'hFF, 8'h00);
    directed(2'd3, 16'h5555, 8'h7F, 8'h80, 8'h80, 8'h00, 8'h00, 8'hFF);
    repeat (6) directed(2'd3, 16'h5555, 8'h7F, 8'h80, 8'h80, 8'h00, 8'h00, 8'hFF);
    directed(2'd0, 16'h8001, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    settle();

    apply_levels(8'($urandom_range(90, 20)), 8'($urandom_range(19)),
                 8'($urandom_range(200, 20)), 8'($urandom_range(19)),
                 8'($urandom_range(12)), (8'd1 << $urandom_range(3)) - 8'd1);
    run_random(122);
    settle();

    // Zero delay and zero mask: every frame is a repeat frame.
    apply_levels(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    run_random(122);
    settle();

    apply_levels(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    run_random(122);
    settle();

    // One controller held still with no idling on either side.
    apply_levels(8'd52, 8'd15, 8'd80, 8'd40, 8'd8, 8'd7);
    idle_pct = 0;
    stall_pct = 0;
    hold_frame.drain = 1'b0;
    hold_frame.pad = 2'd2;
    hold_frame.frame = {16'h0101, 8'd100, 8'd0, 8'd0, -8'sd100, 8'd200, 8'd0};
    repeat (HOLD_FRAMES) push_frame(hold_frame);
    settle();
    idle_pct = 23;
    stall_pct = 23;

    // Hold above press and a mask that is not one less than a power of two.
    apply_levels(8'd10, 8'd90, 8'd30, 8'd200, 8'd3, 8'd6);
    run_random(122);
    settle();
    repeat (6) @(posedge clk);

    $display("Sent %0d frames under %0d register settings, including a long steady hold.",
             frames_accepted, settings_used);
    $display("Checked %0d result words, %0d of them repeat frames; %0d mismatches.",
             results_checked, repeat_frames, mismatches);
    if (mismatches == 0 && edge_reports_due.size() == 0) begin
      $display("analog_hysteresis_key_repeat regression: pass");
    end else begin
      $display("analog_hysteresis_key_repeat regression: fail");
    end
    $finish;
  end

endmodule
